[rtl/lllt_pkg.sv]
// lllt_pkg: shared types, constants and command/status codes
// for the least-loaded layer table; no dependencies
`default_nettype none
package lllt_pkg;
   localparam int TABLE_SLOTS = 32;
   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam int ENTRY_W = 64;

   typedef enum logic [2:0] {
      CMD_REGISTER   = 3'd0,
      CMD_UNREGISTER = 3'd1,
      CMD_INCREMENT  = 3'd2,
      CMD_DECREMENT  = 3'd3,
      CMD_QUERY      = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_ALREADY  = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_FIND, S_MODIFY, S_SHIFT, S_SCAN, S_DONE
   } state_type;

   typedef struct packed {
      logic [15:0] group_id;
      logic [31:0] member_id;
      logic [15:0] load;
   } entry_type;

   typedef struct packed {
      logic [SLOT_W-1:0] addr;
      logic              we;
      logic [SLOT_W-1:0] waddr;
      entry_type         wdata;
   } mem_ctl_type;
endpackage
`default_nettype wire

[rtl/lllt_if.sv]
// lllt_if: valid/ready channel interfaces for commands and results
// depends on nothing
`default_nettype none
interface lllt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [15:0] group_id;
   logic [31:0] member_id;
   modport source (output valid, cmd, group_id, member_id, input ready);
   modport sink (input valid, cmd, group_id, member_id, output ready);
endinterface

interface lllt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] member_load;
   logic [31:0] least_loaded_id;
   logic        needs_new_member;
   modport source (output valid, status, member_load, least_loaded_id, needs_new_member,
                   input ready);
   modport sink (input valid, status, member_load, least_loaded_id, needs_new_member,
                 output ready);
endinterface
`default_nettype wire

[rtl/lllt_mem.sv]
// lllt_mem: slot entry memory, one write and one registered read port
// depends on lllt_pkg
`default_nettype none
module lllt_mem (
   input  wire                   clock,
   input  lllt_pkg::mem_ctl_type ctl,
   output lllt_pkg::entry_type   rdata
);
   lllt_pkg::entry_type mem [lllt_pkg::TABLE_SLOTS];
   lllt_pkg::entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      rdata_ff <= mem[ctl.addr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

[rtl/lllt_ctrl.sv]
// lllt_ctrl: command sequencer; find, modify, shift and group scan over the slot memory
// depends on lllt_pkg
`default_nettype none
module lllt_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire  [15:0]            limit,
   input  wire                    start,
   input  wire  [2:0]             cmd,
   input  wire  [15:0]            group_id,
   input  wire  [31:0]            member_id,
   output logic                   busy,
   output logic                   done,
   input  wire                    taken,
   output logic [1:0]             status,
   output logic [15:0]            member_load,
   output logic [31:0]            least_id,
   output logic                   needs_new,
   output lllt_pkg::mem_ctl_type  mem_ctl,
   input  lllt_pkg::entry_type    rdata
);
   localparam int unsigned LAST = lllt_pkg::TABLE_SLOTS;

   lllt_pkg::state_type state_ff, state_in;
   logic [lllt_pkg::CNT_W-1:0] count_ff, count_in;
   logic [lllt_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic                       rd_ok_ff, rd_ok_in;
   logic [lllt_pkg::SLOT_W-1:0] hit_ff, hit_in;
   logic                       found_ff, found_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [15:0] grp_ff, grp_in;
   logic [31:0] mem_ff, mem_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] load_ff, load_in;
   logic [31:0] best_id_ff, best_id_in;
   logic [15:0] best_ld_ff, best_ld_in;
   logic        any_ff, any_in;
   logic        full_ff, full_in;
   logic        match;
   logic        in_grp;
   logic [lllt_pkg::CNT_W-1:0] rd_idx;
   lllt_pkg::entry_type upd;

   // entry at idx_ff-1 is in rdata when rd_ok_ff
   assign rd_idx = idx_ff - 1'b1;
   assign in_grp = rdata.group_id == grp_ff;
   assign match = in_grp && rdata.member_id == mem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lllt_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
      rd_ok_ff <= rd_ok_in;
      hit_ff <= hit_in;
      found_ff <= found_in;
      cmd_ff <= cmd_in;
      grp_ff <= grp_in;
      mem_ff <= mem_in;
      status_ff <= status_in;
      load_ff <= load_in;
      best_id_ff <= best_id_in;
      best_ld_ff <= best_ld_in;
      any_ff <= any_in;
      full_ff <= full_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lllt_pkg::S_IDLE: if (start) state_in = lllt_pkg::S_FIND;
         lllt_pkg::S_FIND: begin
            if ((rd_ok_ff && match) || (!rd_ok_ff && idx_ff >= count_ff)) begin
               state_in = lllt_pkg::S_MODIFY;
            end
         end
         lllt_pkg::S_MODIFY: begin
            if (found_ff && cmd_ff == lllt_pkg::CMD_UNREGISTER) state_in = lllt_pkg::S_SHIFT;
            else state_in = lllt_pkg::S_SCAN;
         end
         lllt_pkg::S_SHIFT: if (!rd_ok_ff && idx_ff >= count_ff) state_in = lllt_pkg::S_SCAN;
         lllt_pkg::S_SCAN: if (!rd_ok_ff && idx_ff >= count_ff) state_in = lllt_pkg::S_DONE;
         lllt_pkg::S_DONE: if (taken) state_in = lllt_pkg::S_IDLE;
         default: state_in = lllt_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in = count_ff;
      idx_in = idx_ff;
      rd_ok_in = 1'b0;
      hit_in = hit_ff;
      found_in = found_ff;
      cmd_in = cmd_ff;
      grp_in = grp_ff;
      mem_in = mem_ff;
      status_in = status_ff;
      load_in = load_ff;
      best_id_in = best_id_ff;
      best_ld_in = best_ld_ff;
      any_in = any_ff;
      full_in = full_ff;
      upd = rdata;
      mem_ctl.addr = idx_ff[lllt_pkg::SLOT_W-1:0];
      mem_ctl.we = 1'b0;
      mem_ctl.waddr = hit_ff;
      mem_ctl.wdata = rdata;
      case (state_ff)
         lllt_pkg::S_IDLE: begin
            idx_in = '0;
            found_in = 1'b0;
            cmd_in = cmd;
            grp_in = group_id;
            mem_in = member_id;
         end
         lllt_pkg::S_FIND: begin
            if (rd_ok_ff && match) begin
               found_in = 1'b1;
               hit_in = rd_idx[lllt_pkg::SLOT_W-1:0];
               load_in = rdata.load;
            end else if (idx_ff < count_ff) begin
               idx_in = idx_ff + 1'b1;
               rd_ok_in = 1'b1;
            end
         end
         lllt_pkg::S_MODIFY: begin
            status_in = lllt_pkg::ST_OK;
            load_in = '0;
            idx_in = '0;
            if (cmd_ff == lllt_pkg::CMD_REGISTER) begin
               if (found_ff) begin
                  status_in = lllt_pkg::ST_ALREADY;
                  load_in = load_ff;
               end else if (count_ff >= LAST[lllt_pkg::CNT_W-1:0]) begin
                  status_in = lllt_pkg::ST_FULL;
               end else begin
                  mem_ctl.we = 1'b1;
                  mem_ctl.waddr = count_ff[lllt_pkg::SLOT_W-1:0];
                  mem_ctl.wdata = '{group_id: grp_ff, member_id: mem_ff, load: 16'd0};
                  count_in = count_ff + 1'b1;
               end
            end else if (!found_ff) begin
               status_in = lllt_pkg::ST_NOT_FOUND;
            end else if (cmd_ff == lllt_pkg::CMD_UNREGISTER) begin
               idx_in = {1'b0, hit_ff} + 1'b1;
            end else begin
               upd = '{group_id: grp_ff, member_id: mem_ff, load: load_ff};
               if (cmd_ff == lllt_pkg::CMD_INCREMENT && load_ff != 16'hFFFF) begin
                  upd.load = load_ff + 1'b1;
               end else if (cmd_ff == lllt_pkg::CMD_DECREMENT && load_ff != 16'd0) begin
                  upd.load = load_ff - 1'b1;
               end
               mem_ctl.we = 1'b1;
               mem_ctl.wdata = upd;
               load_in = upd.load;
            end
         end
         lllt_pkg::S_SHIFT: begin
            // read slot i, write it to slot i-1
            if (rd_ok_ff) begin
               mem_ctl.we = 1'b1;
               mem_ctl.waddr = rd_idx[lllt_pkg::SLOT_W-1:0] - 1'b1;
            end
            if (idx_ff < count_ff) begin
               idx_in = idx_ff + 1'b1;
               rd_ok_in = 1'b1;
            end else if (!rd_ok_ff) begin
               count_in = count_ff - 1'b1;
               idx_in = '0;
            end
            any_in = 1'b0;
            full_in = 1'b1;
            best_id_in = '0;
         end
         lllt_pkg::S_SCAN: begin
            if (rd_ok_ff && in_grp) begin
               if (!any_ff || rdata.load < best_ld_ff) begin
                  best_ld_in = rdata.load;
                  best_id_in = rdata.member_id;
               end
               any_in = 1'b1;
               if (rdata.load < limit) full_in = 1'b0;
            end
            if (idx_ff < count_ff) begin
               idx_in = idx_ff + 1'b1;
               rd_ok_in = 1'b1;
            end
         end
         lllt_pkg::S_DONE: ;
         default: ;
      endcase
      if (state_ff == lllt_pkg::S_MODIFY) begin
         any_in = 1'b0;
         full_in = 1'b1;
         best_id_in = '0;
      end
   end

   // outputs
   always_comb begin
      busy = state_ff != lllt_pkg::S_IDLE;
      done = state_ff == lllt_pkg::S_DONE;
      status = status_ff;
      member_load = load_ff;
      least_id = best_id_ff;
      needs_new = any_ff && full_ff;
   end
endmodule
`default_nettype wire

[rtl/least_loaded_layer_table.sv]
// least_loaded_layer_table: top level, csr register, channels, sequencer and slot memory
// depends on lllt_pkg, lllt_if, lllt_mem, lllt_ctrl
//
// usage: one command transfer on req (cmd, group_id, member_id) yields exactly
// one result transfer on rsp (status, member_load, least_loaded_id,
// needs_new_member). entries sit packed in registration order in a 32 x 64-bit
// synchronous memory with a registered read port; a fill count marks the used
// slots, so no clearing pass is needed after reset.
// a command runs: find, modify, on unregister a shift of later entries down one
// slot, then a group scan over the used slots; these steps run one after
// another through the single memory read port.
// one command is in flight at a time: req.ready is high only when idle.
// the result stays on rsp until taken; a stalled receiver holds the block.
// reset (synchronous, active high) empties the table and sets
// max_load_per_member to 1000; csr writes are taken any cycle but are meant
// for when the block is idle.
`default_nettype none
module least_loaded_layer_table (
   input  wire          clock,
   input  wire          reset,
   lllt_req_if.sink     req,
   lllt_rsp_if.source   rsp,
   input  wire          csr_we,
   input  wire  [15:0]  csr_wdata
);
   logic [15:0] limit_ff;
   logic        busy;
   logic        done;
   lllt_pkg::mem_ctl_type mem_ctl;
   lllt_pkg::entry_type   rdata;

   // load limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 16'd1000;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   assign req.ready = !busy;
   assign rsp.valid = done;

   lllt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .limit       (limit_ff),
      .start       (req.valid && !busy),
      .cmd         (req.cmd),
      .group_id    (req.group_id),
      .member_id   (req.member_id),
      .busy        (busy),
      .done        (done),
      .taken       (rsp.ready),
      .status      (rsp.status),
      .member_load (rsp.member_load),
      .least_id    (rsp.least_loaded_id),
      .needs_new   (rsp.needs_new_member),
      .mem_ctl     (mem_ctl),
      .rdata       (rdata)
   );

   // slot memory
   lllt_mem u_mem (
      .clock (clock),
      .ctl   (mem_ctl),
      .rdata (rdata)
   );
endmodule
`default_nettype wire
